@@ hw/rtl/shac_pkg.sv @@
// ----------------------------------------------------------------------------
// shac_pkg
// Shared types and constants for the snapshot histogram accumulator.
// ----------------------------------------------------------------------------
package shac_pkg;

    // Bin storage geometry
    localparam int NUM_BINS = 32;
    localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // Accumulator widths
    localparam int CS_W = 48;
    localparam int CC_W = 24;
    localparam int TS_W = 56;
    localparam int TC_W = 32;
    localparam int SC_W = 32;

    // Divider geometry: magnitude of a total sum over a 32 bit count
    localparam int DIV_N = TS_W;
    localparam int DIV_D = TC_W;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    // Operation codes carried on the input sideband
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SNAP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_DUMP  = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZDIV  = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RANGE_LOW  = 2'd0,
        REG_RANGE_HIGH = 2'd1,
        REG_BIN_WIDTH  = 2'd2,
        REG_BIN_RECIP  = 2'd3
    } t_reg;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hw/rtl/shac_div.sv @@
// ----------------------------------------------------------------------------
// shac_div
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module shac_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [shac_pkg::DIV_N-1:0]    i_dividend,
    input  logic [shac_pkg::DIV_D-1:0]    i_divisor,
    output logic [shac_pkg::DIV_N-1:0]    o_quotient,
    output shac_pkg::t_div_stat           o_stat
);
    import shac_pkg::*;

    logic [DIV_N-1:0]     r_q;
    logic [DIV_D-1:0]     r_rem;
    logic [DIV_D-1:0]     r_d;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_D:0]       trial;
    logic [DIV_D:0]       diff;
    logic                 ge;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_q[DIV_N-1]};
        diff  = trial - {1'b0, r_d};
        ge    = (trial >= {1'b0, r_d});
    end

    // Control: busy over DIV_N steps, done pulse after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
            r_q   <= {r_q[DIV_N-2:0], ge};
        end
    end

    assign o_quotient  = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ hw/rtl/snapshot_histogram_accumulator.sv @@
// ----------------------------------------------------------------------------
// snapshot_histogram_accumulator
// Binned Q16.16 histogram with per-snapshot bins, running totals and a dump
// that reports each bin's center and averaged total.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                          sideband
//  s_axis    in         sample_value, position                      tuser: op, reduce_mode
//  m_axis    out        bin_center, reduced_value, bin_number, pad  tuser: status; tlast
//  apb       in         range_low, range_high, bin_width, recip     4 byte stride
//
//  An add steps through multiply, clamp, bin read, write and result. An end of
//  snapshot walks the bins with a read and a write state each. A clear goes
//  straight to its result. A dump passes each bin through the bit-serial
//  divider (56 steps). Reset clears per-bin valid flags, so no clearing pass.
//  Input is taken only while the sequencer is idle; one output register holds
//  a result while the next beat is accepted, and the sequencer stalls on it.
// ----------------------------------------------------------------------------
module snapshot_histogram_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // sample_value[31:0], position[63:32]
    input  logic [2:0]  s_axis_tuser,   // op[1:0], reduce_mode[2]
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // bin_center[31:0], reduced_value[63:32],
                                        // bin_number[69:64], zero[71:70]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import shac_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_ADD_MUL = 11'b000_0000_0010,
        S_ADD_IDX = 11'b000_0000_0100,
        S_ADD_RD  = 11'b000_0000_1000,
        S_ADD_WR  = 11'b000_0001_0000,
        S_SNAP_RD = 11'b000_0010_0000,
        S_SNAP_WR = 11'b000_0100_0000,
        S_DMP_RD  = 11'b000_1000_0000,
        S_DMP_CHK = 11'b001_0000_0000,
        S_DMP_DIV = 11'b010_0000_0000,
        S_EMIT    = 11'b100_0000_0000
    } t_state;

    // Configuration registers
    logic [31:0] r_range_low, r_range_high, r_bin_width, r_bin_recip;

    // Sequencer state and latched beat
    t_state             r_state, n_state;
    t_op                r_op;
    logic signed [31:0] r_val, r_pos;
    logic               r_mode;
    logic [BIN_W-1:0]   r_idx;
    logic [31:0]        r_binhi;
    logic [36:0]        r_half;
    logic               r_neg;
    logic [SC_W-1:0]    r_snap;

    // Pending result
    logic [31:0] r_p_center, r_p_red;
    logic [5:0]  r_p_bin;
    t_status     r_p_status;

    // Output register
    logic        r_ovld;
    logic [31:0] r_o_center, r_o_red;
    logic [5:0]  r_o_bin;
    t_status     r_o_status;
    logic        r_o_last;

    // Bin memories, registered reads
    logic [CS_W-1:0] mem_cs [NUM_BINS];
    logic [CC_W-1:0] mem_cc [NUM_BINS];
    logic [TS_W-1:0] mem_ts [NUM_BINS];
    logic [TC_W-1:0] mem_tc [NUM_BINS];
    logic [NUM_BINS-1:0] r_cvld, r_tvld;
    logic [CS_W-1:0] r_rd_cs;
    logic [CC_W-1:0] r_rd_cc;
    logic [TS_W-1:0] r_rd_ts;
    logic [TC_W-1:0] r_rd_tc;
    logic            r_rd_cv, r_rd_tv;

    // Divider hookup
    logic             div_start;
    logic [DIV_N-1:0] div_dividend;
    logic [DIV_D-1:0] div_divisor;
    logic [DIV_N-1:0] div_q;
    t_div_stat        div_stat;

    // Combinational helpers
    logic            in_acc, cfg_wr, out_free, last_bin, more_bins;
    logic [CS_W-1:0] cs_eff, cs_new;
    logic [CC_W-1:0] cc_eff, cc_new;
    logic [TS_W-1:0] ts_eff, ts_new;
    logic [TC_W-1:0] tc_eff, tc_new, dmp_div;
    logic [CS_W:0]   cs_sum;
    logic [TS_W:0]   ts_sum;
    logic [TC_W:0]   tc_sum;
    logic            in_range;
    logic [31:0]     diff32;
    logic [63:0]     prod;
    logic [37:0]     hprod;
    logic [38:0]     csum;
    logic [31:0]     center_sat;
    logic [31:0]     red_sat;
    logic [BIN_W-1:0] bin_clamp;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_ovld || m_axis_tready;
    assign last_bin = (r_idx == BIN_W'(NUM_BINS - 1));
    assign more_bins = (r_op == OP_DUMP) && !last_bin;

    // Configuration write and read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= 32'd0;
            r_range_high <= 32'd65536;
            r_bin_width  <= 32'd2048;
            r_bin_recip  <= 32'd2097152;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_RANGE_LOW:  r_range_low  <= pwdata;
                REG_RANGE_HIGH: r_range_high <= pwdata;
                REG_BIN_WIDTH:  r_bin_width  <= pwdata;
                REG_BIN_RECIP:  r_bin_recip  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_RANGE_LOW:  prdata = r_range_low;
            REG_RANGE_HIGH: prdata = r_range_high;
            REG_BIN_WIDTH:  prdata = r_bin_width;
            REG_BIN_RECIP:  prdata = r_bin_recip;
            default:        prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // Effective bin contents: entries whose valid flag is clear read as zero
    always_comb begin
        cs_eff = r_rd_cv ? r_rd_cs : '0;
        cc_eff = r_rd_cv ? r_rd_cc : '0;
        ts_eff = r_rd_tv ? r_rd_ts : '0;
        tc_eff = r_rd_tv ? r_rd_tc : '0;
    end

    // Saturating bin updates
    always_comb begin
        cs_sum = {cs_eff[CS_W-1], cs_eff} + (CS_W+1)'(r_val);
        if (cs_sum[CS_W] != cs_sum[CS_W-1])
            cs_new = {cs_sum[CS_W], {(CS_W-1){~cs_sum[CS_W]}}};
        else
            cs_new = cs_sum[CS_W-1:0];
        cc_new = (&cc_eff) ? cc_eff : cc_eff + 1'b1;

        ts_sum = {ts_eff[TS_W-1], ts_eff}
               + {{(TS_W-CS_W+1){cs_eff[CS_W-1]}}, cs_eff};
        if (ts_sum[TS_W] != ts_sum[TS_W-1])
            ts_new = {ts_sum[TS_W], {(TS_W-1){~ts_sum[TS_W]}}};
        else
            ts_new = ts_sum[TS_W-1:0];
        tc_sum = {1'b0, tc_eff} + (TC_W+1)'(cc_eff);
        tc_new = tc_sum[TC_W] ? {TC_W{1'b1}} : tc_sum[TC_W-1:0];
    end

    // Bin lookup: range check, Q32.32 product, clamp
    always_comb begin
        in_range = (r_pos >= $signed(r_range_low)) && (r_pos <= $signed(r_range_high));
        diff32   = r_pos - r_range_low;
        prod     = 64'(diff32) * 64'(r_bin_recip);
        bin_clamp = (r_binhi >= 32'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : r_binhi[BIN_W-1:0];
    end

    // Dump: bin center and divisor selection
    always_comb begin
        hprod = 38'({1'b0, r_idx, 1'b1}) * 38'(r_bin_width);
        csum  = {{7{r_range_low[31]}}, r_range_low} + 39'(r_half);
        if (csum[38] && !(&csum[37:31]))
            center_sat = 32'h8000_0000;
        else if (!csum[38] && (|csum[37:31]))
            center_sat = 32'h7FFF_FFFF;
        else
            center_sat = csum[31:0];
        dmp_div = r_mode ? tc_eff : r_snap;
    end

    // Dump: signed and saturated quotient
    always_comb begin
        if (r_neg) begin
            if (div_q > DIV_N'(33'h0_8000_0000))
                red_sat = 32'h8000_0000;
            else
                red_sat = 32'd0 - div_q[31:0];
        end else begin
            if (div_q > DIV_N'(32'h7FFF_FFFF))
                red_sat = 32'h7FFF_FFFF;
            else
                red_sat = div_q[31:0];
        end
    end

    assign div_start    = (r_state == S_DMP_CHK) && (dmp_div != '0);
    assign div_dividend = ts_eff[TS_W-1] ? (DIV_N'(0) - ts_eff) : ts_eff;
    assign div_divisor  = dmp_div;

    shac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_op'(s_axis_tuser[1:0]))
                        OP_ADD:   n_state = S_ADD_MUL;
                        OP_SNAP:  n_state = S_SNAP_RD;
                        OP_DUMP:  n_state = S_DMP_RD;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_ADD_MUL: n_state = in_range ? S_ADD_IDX : S_EMIT;
            S_ADD_IDX: n_state = S_ADD_RD;
            S_ADD_RD:  n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_EMIT;
            S_SNAP_RD: n_state = S_SNAP_WR;
            S_SNAP_WR: n_state = last_bin ? S_EMIT : S_SNAP_RD;
            S_DMP_RD:  n_state = S_DMP_CHK;
            S_DMP_CHK: n_state = (dmp_div == '0) ? S_EMIT : S_DMP_DIV;
            S_DMP_DIV: n_state = div_stat.done ? S_EMIT : S_DMP_DIV;
            S_EMIT: begin
                if (out_free)
                    n_state = more_bins ? S_DMP_RD : S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // Output valid: load on emit, drop once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    // Sequencer registers and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_ADD;
            r_idx   <= '0;
            r_snap  <= '0;
            r_cvld  <= '0;
            r_tvld  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= t_op'(s_axis_tuser[1:0]);
                        r_idx <= '0;
                        if (t_op'(s_axis_tuser[1:0]) == OP_CLEAR) begin
                            r_cvld <= '0;
                            r_tvld <= '0;
                            r_snap <= '0;
                        end
                    end
                end
                S_ADD_IDX: r_idx <= bin_clamp;
                S_ADD_WR:  r_cvld[r_idx] <= 1'b1;
                S_SNAP_WR: begin
                    r_tvld[r_idx] <= 1'b1;
                    r_cvld[r_idx] <= 1'b0;
                    if (last_bin) begin
                        if (!(&r_snap))
                            r_snap <= r_snap + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (out_free && more_bins)
                        r_idx <= r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: latched beat, pending result, output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_val      <= s_axis_tdata[31:0];
            r_pos      <= s_axis_tdata[63:32];
            r_mode     <= s_axis_tuser[2];
            r_p_center <= '0;
            r_p_red    <= '0;
            r_p_bin    <= '0;
            r_p_status <= ST_OK;
        end
        if (r_state == S_ADD_MUL) begin
            r_binhi <= prod[63:32];
            if (!in_range)
                r_p_status <= ST_RANGE;
        end
        if (r_state == S_ADD_WR)
            r_p_bin <= 6'(r_idx);
        if (r_state == S_DMP_RD)
            r_half <= hprod[37:1];
        if (r_state == S_DMP_CHK) begin
            r_p_center <= center_sat;
            r_p_bin    <= 6'(r_idx);
            r_neg      <= ts_eff[TS_W-1];
            r_p_red    <= '0;
            r_p_status <= (dmp_div == '0) ? ST_ZDIV : ST_OK;
        end
        if ((r_state == S_DMP_DIV) && div_stat.done)
            r_p_red <= red_sat;
        if ((r_state == S_EMIT) && out_free) begin
            r_o_center <= r_p_center;
            r_o_red    <= r_p_red;
            r_o_bin    <= r_p_bin;
            r_o_status <= r_p_status;
            r_o_last   <= !more_bins;
        end
    end

    // Bin memories: one write and one registered read per array
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD_WR) begin
            mem_cs[r_idx] <= cs_new;
            mem_cc[r_idx] <= cc_new;
        end
        if (r_state == S_SNAP_WR) begin
            mem_ts[r_idx] <= ts_new;
            mem_tc[r_idx] <= tc_new;
        end
        r_rd_cs <= mem_cs[r_idx];
        r_rd_cc <= mem_cc[r_idx];
        r_rd_ts <= mem_ts[r_idx];
        r_rd_tc <= mem_tc[r_idx];
    end

    // Valid flags follow the read address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cv <= 1'b0;
            r_rd_tv <= 1'b0;
        end else begin
            r_rd_cv <= r_cvld[r_idx];
            r_rd_tv <= r_tvld[r_idx];
        end
    end

    // Drive result beat
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {2'b00, r_o_bin, r_o_red, r_o_center};
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;

endmodule
